// ----- src/overwrite_ring_event_buffer_unit_macros.svh -----
// Assertion macros shared by the ring event buffer RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef OVERWRITE_RING_EVENT_BUFFER_UNIT_MACROS_SVH
`define OVERWRITE_RING_EVENT_BUFFER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define OREB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("oreb assertion failed");
// next-cycle implication
`define OREB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("oreb assertion failed");
`else
`define OREB_ASSERT_NOW(lbl, ante, cons)
`define OREB_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- src/oreb_pkg.sv -----
// Shared constants, request codes and command struct for the ring event buffer.
// No dependencies; used by every RTL module of the block.
package oreb_pkg;

  localparam int CAPACITY    = 1024;
  localparam int EVENT_WIDTH = 64;
  localparam int MAX_BATCH   = 64;

  localparam int IDX_W   = $clog2(CAPACITY);
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int BATCH_W = $clog2(MAX_BATCH + 1);
  localparam int CMP_W   = (CNT_W > BATCH_W) ? CNT_W : BATCH_W;

  // port widths fixed by the interface
  localparam int REQ_W   = 2;
  localparam int DATA_W  = 64;
  localparam int MAXC_W  = 7;
  localparam int PEND_W  = 11;
  localparam int TOTAL_W = 64;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  typedef enum logic [REQ_W-1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_STATS = 2'd3
  } req_t;

  typedef struct packed {
    req_t                   op;
    logic [EVENT_WIDTH-1:0] data;
    logic [BATCH_W-1:0]     want;   // batch limit already saturated
  } cmd_t;

endpackage

// ----- src/oreb_front.sv -----
// Front end: accepts request items, decodes and saturates them, and holds
// them in a two-entry command queue. Depends on oreb_pkg.
module oreb_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [oreb_pkg::REQ_W-1:0]   in_req_type,
  input  logic [oreb_pkg::DATA_W-1:0]  in_event_data,
  input  logic [oreb_pkg::MAXC_W-1:0]  in_batch_limit,
  output logic                         cmd_valid,
  output oreb_pkg::cmd_t               cmd,
  input  logic                         cmd_pop
);

  oreb_pkg::cmd_t q_mem_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     count_r, count_nxt;
  oreb_pkg::cmd_t dec;
  logic           push;

  // classify the incoming item
  always_comb begin
    dec.op   = oreb_pkg::req_t'(in_req_type);
    dec.data = in_event_data[oreb_pkg::EVENT_WIDTH-1:0];
    if (in_batch_limit > oreb_pkg::MAXC_W'(oreb_pkg::MAX_BATCH)) begin
      dec.want = oreb_pkg::BATCH_W'(oreb_pkg::MAX_BATCH);
    end else begin
      dec.want = in_batch_limit[oreb_pkg::BATCH_W-1:0];
    end
  end

  assign in_stall  = (count_r == 2'd2);
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (count_r != 2'd0);
  assign cmd       = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = cmd_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, cmd_pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- src/oreb_back.sv -----
// Back end: executes queued commands against the event store and the
// counters, and drives the registered result channel. Depends on oreb_pkg.
`include "overwrite_ring_event_buffer_unit_macros.svh"
module oreb_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cmd_valid,
  input  oreb_pkg::cmd_t                cmd,
  output logic                          cmd_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_status,
  output logic [oreb_pkg::DATA_W-1:0]   out_event_out,
  output logic                          out_last,
  output logic [oreb_pkg::PEND_W-1:0]   out_pending_count,
  output logic [oreb_pkg::TOTAL_W-1:0]  out_total_written,
  output logic [oreb_pkg::TOTAL_W-1:0]  out_dropped_count
);

  typedef enum logic {S_IDLE, S_BATCH} state_t;

  localparam logic [oreb_pkg::BATCH_W-1:0] BATCH_ONE = oreb_pkg::BATCH_W'(1);

  logic [oreb_pkg::EVENT_WIDTH-1:0] store_mem [oreb_pkg::CAPACITY];
  logic [oreb_pkg::EVENT_WIDTH-1:0] rd_data_r;

  state_t                        state_r, state_nxt;
  logic [oreb_pkg::IDX_W-1:0]    wr_idx_r, wr_idx_nxt;
  logic [oreb_pkg::IDX_W-1:0]    rd_idx_r, rd_idx_nxt;
  logic [oreb_pkg::CNT_W-1:0]    fill_r, fill_nxt;
  logic [oreb_pkg::TOTAL_W-1:0]  total_r, total_nxt;
  logic [oreb_pkg::TOTAL_W-1:0]  drop_r, drop_nxt;
  logic [oreb_pkg::BATCH_W-1:0]  rem_r, rem_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          status_r, status_nxt;
  logic                          last_r, last_nxt;
  logic                          ev_sel_r, ev_sel_nxt;

  logic                          load;
  logic                          wr_en;
  logic                          rd_en;
  logic [oreb_pkg::CMP_W-1:0]    want_c;
  logic [oreb_pkg::CMP_W-1:0]    fill_c;
  logic [oreb_pkg::BATCH_W-1:0]  n_pop;

  function automatic logic [oreb_pkg::IDX_W-1:0] next_idx(
    input logic [oreb_pkg::IDX_W-1:0] i
  );
    return (i == oreb_pkg::IDX_W'(oreb_pkg::CAPACITY - 1)) ? '0 : i + 1'b1;
  endfunction

  // result slot is free at this edge
  assign load = !out_valid_r || !out_stall;

  // events popped by a batch read: min(want, fill)
  always_comb begin
    want_c = oreb_pkg::CMP_W'(cmd.want);
    fill_c = oreb_pkg::CMP_W'(fill_r);
    n_pop  = (want_c < fill_c) ? cmd.want : oreb_pkg::BATCH_W'(fill_r);
  end

  always_comb begin
    state_nxt     = state_r;
    wr_idx_nxt    = wr_idx_r;
    rd_idx_nxt    = rd_idx_r;
    fill_nxt      = fill_r;
    total_nxt     = total_r;
    drop_nxt      = drop_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r && out_stall;
    status_nxt    = status_r;
    last_nxt      = last_r;
    ev_sel_nxt    = ev_sel_r;
    cmd_pop       = 1'b0;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid && load) begin
          cmd_pop       = 1'b1;
          out_valid_nxt = 1'b1;
          status_nxt    = oreb_pkg::STATUS_OK;
          last_nxt      = 1'b1;
          ev_sel_nxt    = 1'b0;
          unique case (cmd.op)
            oreb_pkg::REQ_WRITE: begin
              wr_en      = 1'b1;
              wr_idx_nxt = next_idx(wr_idx_r);
              total_nxt  = total_r + 1'b1;
              if (fill_r == oreb_pkg::CNT_W'(oreb_pkg::CAPACITY)) begin
                // full: oldest event is overwritten
                rd_idx_nxt = next_idx(rd_idx_r);
                drop_nxt   = drop_r + 1'b1;
              end else begin
                fill_nxt = fill_r + 1'b1;
              end
            end
            oreb_pkg::REQ_CLEAR: begin
              wr_idx_nxt = '0;
              rd_idx_nxt = '0;
              fill_nxt   = '0;
            end
            oreb_pkg::REQ_STATS: begin
            end
            oreb_pkg::REQ_READ: begin
              if (n_pop == '0) begin
                status_nxt = oreb_pkg::STATUS_EMPTY;
              end else begin
                // fill drops by the whole batch up front so every result
                // reports the count after the request
                rd_en      = 1'b1;
                rd_idx_nxt = next_idx(rd_idx_r);
                fill_nxt   = fill_r - oreb_pkg::CNT_W'(n_pop);
                ev_sel_nxt = 1'b1;
                last_nxt   = (n_pop == BATCH_ONE);
                rem_nxt    = n_pop - 1'b1;
                if (n_pop != BATCH_ONE) begin
                  state_nxt = S_BATCH;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_BATCH: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          status_nxt    = oreb_pkg::STATUS_OK;
          ev_sel_nxt    = 1'b1;
          rd_en         = 1'b1;
          rd_idx_nxt    = next_idx(rd_idx_r);
          rem_nxt       = rem_r - 1'b1;
          last_nxt      = (rem_r == BATCH_ONE);
          if (rem_r == BATCH_ONE) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // event store; the read register doubles as the result payload register
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[wr_idx_r] <= cmd.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= store_mem[rd_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wr_idx_r    <= '0;
      rd_idx_r    <= '0;
      fill_r      <= '0;
      total_r     <= '0;
      drop_r      <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
      status_r    <= oreb_pkg::STATUS_OK;
      last_r      <= 1'b0;
      ev_sel_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_idx_r    <= wr_idx_nxt;
      rd_idx_r    <= rd_idx_nxt;
      fill_r      <= fill_nxt;
      total_r     <= total_nxt;
      drop_r      <= drop_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
      status_r    <= status_nxt;
      last_r      <= last_nxt;
      ev_sel_r    <= ev_sel_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_last          = last_r;
  assign out_event_out     = ev_sel_r ? oreb_pkg::DATA_W'(rd_data_r) : '0;
  assign out_pending_count = oreb_pkg::PEND_W'(fill_r);
  assign out_total_written = total_r;
  assign out_dropped_count = drop_r;

  `OREB_ASSERT_NOW(a_fill_cap, 1'b1, fill_r <= oreb_pkg::CNT_W'(oreb_pkg::CAPACITY))
  `OREB_ASSERT_NOW(a_batch_busy, state_r == S_BATCH, out_valid_r && ev_sel_r && !last_r)
  `OREB_ASSERT_NOW(a_batch_rem, state_r == S_BATCH, rem_r != '0)
  `OREB_ASSERT_NEXT(a_hold_counts, out_valid_r && out_stall,
                    $stable(fill_r) && $stable(total_r) && $stable(drop_r))
  `OREB_ASSERT_NOW(a_no_pop_busy, cmd_pop, load && cmd_valid)

endmodule

// ----- src/overwrite_ring_event_buffer_unit.sv -----
// Overwrite-oldest ring event buffer top: front queue, back executor; uses oreb_pkg.
// A request item is queued in the front; its result item is registered in the back end.
// Throughput: one write, clear or stats item per unstalled cycle; a batch read of n
//   events gives n result items, one per unstalled cycle, one store read each; the input
//   stalls once the two-entry queue fills behind a streaming batch or a stalled result.
// Reset (rst_n low, synchronous) empties the buffer and zeroes both lifetime counters.
module overwrite_ring_event_buffer_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [oreb_pkg::REQ_W-1:0]    in_req_type,
  input  logic [oreb_pkg::DATA_W-1:0]   in_event_data,
  input  logic [oreb_pkg::MAXC_W-1:0]   in_batch_limit,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_status,
  output logic [oreb_pkg::DATA_W-1:0]   out_event_out,
  output logic                          out_last,
  output logic [oreb_pkg::PEND_W-1:0]   out_pending_count,
  output logic [oreb_pkg::TOTAL_W-1:0]  out_total_written,
  output logic [oreb_pkg::TOTAL_W-1:0]  out_dropped_count
);

  // Decoded command handed from the front queue to the executor. The
  // front saturates the batch limit and keeps only EVENT_WIDTH payload bits.
  // The event store itself is never cleared; reads only reach written slots.
  oreb_pkg::cmd_t cmd;
  logic           cmd_valid;
  logic           cmd_pop;

  // Front: accepts an item whenever its two-entry queue has room, so
  // requests keep flowing while the executor waits on a stalled result.
  oreb_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_event_data  (in_event_data),
    .in_batch_limit (in_batch_limit),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .cmd_pop        (cmd_pop)
  );

  // Back: owns the event store, both indices, the fill count and the
  // lifetime counters. A batch read takes the whole pop count off the
  // fill count on its first result, so every result of the batch
  // reports the state after the request; the events then stream out
  // one per unstalled cycle, the store read register serving as output register.
  oreb_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd_valid         (cmd_valid),
    .cmd               (cmd),
    .cmd_pop           (cmd_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_event_out     (out_event_out),
    .out_last          (out_last),
    .out_pending_count (out_pending_count),
    .out_total_written (out_total_written),
    .out_dropped_count (out_dropped_count)
  );

endmodule
